// ===== design/averaged_rail_window_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// averaged rail window monitor assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef AVERAGED_RAIL_WINDOW_MONITOR_MACROS_SVH
`define AVERAGED_RAIL_WINDOW_MONITOR_MACROS_SVH

`ifndef SYNTHESIS
`define ARWM_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("arwm check failed");
`define ARWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arwm check failed");
`else
`define ARWM_ASSERT(label, expr)
`define ARWM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/arwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwm_pkg
// shared types and constants of the averaged rail window monitor
// ----------------------------------------------------------------------------
package arwm_pkg;

  localparam int AVG_COUNT = 10;
  localparam int MV_SHIFT  = 10;

  localparam int SAMPLE_W  = 10;
  localparam int REG_W     = 13;
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int PINS_W    = 3;

  localparam int ROUND_W   = $clog2(AVG_COUNT + 1);
  localparam int REM_W     = $clog2(AVG_COUNT + 1);
  localparam int RSUM_W    = REM_W + 1;
  localparam int PROD_W    = SAMPLE_W + REG_W;

  // reciprocal for dividing a single sample by the average count
  localparam int DIV_SHIFT = 20;
  localparam int RECIP     = ((1 << DIV_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int DPROD_W   = SAMPLE_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_5V   = 3'd0,
    REG_HIGH_5V  = 3'd1,
    REG_LOW_VIO  = 3'd2,
    REG_HIGH_VIO = 3'd3,
    REG_LOW_3V3  = 3'd4,
    REG_HIGH_3V3 = 3'd5,
    REG_REF_MV   = 3'd6
  } reg_idx_t;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    13'd897, 13'd1096, 13'd340, 13'd376, 13'd624, 13'd690, 13'd1100
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_5v;
    logic [SAMPLE_W-1:0] sample_vio;
    logic [SAMPLE_W-1:0] sample_3v3;
    logic                report_polarity;
  } in_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] test_pins;
    logic [PINS_W-1:0] rail_good;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic accum;
  } rail_ctl_t;

endpackage

// ===== design/arwm_rail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwm_rail
// one rail: running quotient and remainder of the sample sum by the average
// count, scaling to millivolts and the strict window test
// ----------------------------------------------------------------------------
`include "averaged_rail_window_monitor_macros.svh"

module arwm_rail
  import arwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rail_ctl_t           ctl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [REG_W-1:0]    low_mv,
  input  logic [REG_W-1:0]    high_mv,
  input  logic [REG_W-1:0]    ref_mv,
  output logic                in_window
);

  logic [SAMPLE_W-1:0] quot_r, quot_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;

  logic [DPROD_W-1:0]  dprod;
  logic [SAMPLE_W-1:0] s_quot;
  logic [SAMPLE_W-1:0] s_back;
  logic [REM_W-1:0]    s_rem;
  logic [RSUM_W-1:0]   rsum;
  logic                carry;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   mv;

  // sample / count and sample % count
  assign dprod  = DPROD_W'(sample) * DPROD_W'(RECIP);
  assign s_quot = SAMPLE_W'(dprod >> DIV_SHIFT);
  assign s_back = SAMPLE_W'(s_quot * SAMPLE_W'(AVG_COUNT));
  assign s_rem  = REM_W'(sample - s_back);
  assign rsum   = RSUM_W'(rem_r) + RSUM_W'(s_rem);
  assign carry  = (rsum >= RSUM_W'(AVG_COUNT));

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (ctl.step) begin
      if (ctl.accum) begin
        quot_nxt = quot_r + s_quot + SAMPLE_W'(carry);
        rem_nxt  = carry ? REM_W'(rsum - RSUM_W'(AVG_COUNT)) : REM_W'(rsum);
      end else begin
        quot_nxt = '0;
        rem_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r <= '0;
      rem_r  <= '0;
    end else begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // averaged code to millivolts, then strict window
  assign prod      = PROD_W'(quot_r) * PROD_W'(ref_mv);
  assign mv        = prod >> MV_SHIFT;
  assign in_window = (mv > PROD_W'(low_mv)) && (mv < PROD_W'(high_mv));

  `ARWM_ASSERT(rem_below_count, RSUM_W'(rem_r) < RSUM_W'(AVG_COUNT))
  `ARWM_ASSERT_NEXT(clear_after_eval, ctl.step && !ctl.accum, quot_r == '0 && rem_r == '0)

endmodule

// ===== design/averaged_rail_window_monitor.sv =====
`timescale 1ns / 1ps
// an accepted item goes to the input register, its result to the result register
// throughput: one item per cycle when out_ready does not stall the result register
// each rail's window test: one 10 x 13 multiply and two compares before the output
// reset: synchronous active-low rst_n clears the round count, averages and good mask
// and loads the window and reference registers with their default values
// ----------------------------------------------------------------------------
// averaged_rail_window_monitor
// boxcar averaging of three rail samples with a windowed good mask per rail
// ----------------------------------------------------------------------------
`include "averaged_rail_window_monitor_macros.svh"

module averaged_rail_window_monitor
  import arwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  logic [REG_W-1:0]   cfg_r [NUM_REGS];

  logic               in_vld_r;
  in_item_t           in_item_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [PINS_W-1:0]  good_r, good_nxt;

  logic               advance;
  logic               step;
  rail_ctl_t          ctl;
  logic [PINS_W-1:0]  win;
  logic [PINS_W-1:0]  pins;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign step      = in_vld_r && advance;
  assign in_ready  = !in_vld_r || advance;

  assign ctl.step  = step;
  assign ctl.accum = (round_r < ROUND_W'(AVG_COUNT));

  arwm_rail u_rail_5v (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_item_r.sample_5v),
    .low_mv    (cfg_r[REG_LOW_5V]),
    .high_mv   (cfg_r[REG_HIGH_5V]),
    .ref_mv    (cfg_r[REG_REF_MV]),
    .in_window (win[0])
  );

  arwm_rail u_rail_vio (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_item_r.sample_vio),
    .low_mv    (cfg_r[REG_LOW_VIO]),
    .high_mv   (cfg_r[REG_HIGH_VIO]),
    .ref_mv    (cfg_r[REG_REF_MV]),
    .in_window (win[1])
  );

  arwm_rail u_rail_3v3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (in_item_r.sample_3v3),
    .low_mv    (cfg_r[REG_LOW_3V3]),
    .high_mv   (cfg_r[REG_HIGH_3V3]),
    .ref_mv    (cfg_r[REG_REF_MV]),
    .in_window (win[2])
  );

  always_comb begin
    good_nxt  = good_r;
    round_nxt = round_r;
    if (step) begin
      if (ctl.accum) begin
        round_nxt = round_r + ROUND_W'(1);
      end else begin
        round_nxt = '0;
        good_nxt  = win;
      end
    end
  end

  assign pins = in_item_r.report_polarity ? good_nxt : ~good_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= REG_RESET;
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      good_r      <= '0;
    end else begin
      if (cfg_valid && cfg_index <= REG_REF_MV) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_vld_r;
      end
      round_r <= round_nxt;
      good_r  <= good_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (step) begin
      out_item_r.test_pins <= pins;
      out_item_r.rail_good <= good_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ARWM_ASSERT(round_in_range, round_r <= ROUND_W'(AVG_COUNT))
  `ARWM_ASSERT(out_shows_mask, !out_valid_r || out_item_r.rail_good == good_r)
  `ARWM_ASSERT_NEXT(round_wraps, step && !ctl.accum, round_r == '0)

endmodule
